// ===== design/qsu_pkg.sv =====
package qsu_pkg;

  // Character codes seen in a string body.
  localparam logic [7:0] ChEnd       = 8'h00;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerN    = 8'h6e;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerX    = 8'h78;

  // Control bytes produced by the letter escapes.
  localparam logic [7:0] CtrlTab = 8'h09;
  localparam logic [7:0] CtrlLf  = 8'h0a;
  localparam logic [7:0] CtrlCr  = 8'h0d;
  localparam logic [7:0] CtrlFf  = 8'h0c;

  // Hex digits still expected right after \x.
  localparam logic [1:0] HexDigits = 2'd2;

  typedef enum logic [1:0] {
    StCont  = 2'd0,
    StClose = 2'd1,
    StError = 2'd2
  } status_e;

  // State carried from one byte to the next.
  typedef struct packed {
    logic       escape_pending;
    logic [1:0] hex_left;
    logic [7:0] hex_accum;
  } dec_state_t;

  // One result item.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    status_e    status;
  } dec_result_t;

  // Hex digit decode: bit 4 flags a byte that is not a hex digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== design/qsu_decode.sv =====
module qsu_decode (
  input  logic [7:0]          ch_i,
  input  qsu_pkg::dec_state_t cur_i,
  output qsu_pkg::dec_state_t nxt_o,
  output qsu_pkg::dec_result_t res_o
);

  logic [4:0] nib;

  assign nib = qsu_pkg::hex_nibble(ch_i);

  // Next state and result for one byte of the string body.
  always_comb begin
    nxt_o = cur_i;
    res_o.byte_valid = 1'b0;
    res_o.out_byte   = 8'h00;
    res_o.status     = qsu_pkg::StCont;

    if (ch_i == qsu_pkg::ChEnd) begin
      res_o.status = qsu_pkg::StError;
    end else if (cur_i.escape_pending) begin
      if (cur_i.hex_left != 2'd0) begin
        // Collecting hex digits, high nibble first.
        if (nib[4]) begin
          res_o.status = qsu_pkg::StError;
        end else begin
          nxt_o.hex_left = cur_i.hex_left - 2'd1;
          if (cur_i.hex_left == 2'd2) begin
            nxt_o.hex_accum = cur_i.hex_accum | {nib[3:0], 4'h0};
          end else begin
            nxt_o.hex_accum = cur_i.hex_accum | {4'h0, nib[3:0]};
          end
          if (nxt_o.hex_left == 2'd0) begin
            if (nxt_o.hex_accum == 8'h00) begin
              res_o.status = qsu_pkg::StError;
            end else begin
              res_o.byte_valid     = 1'b1;
              res_o.out_byte       = nxt_o.hex_accum;
              nxt_o.escape_pending = 1'b0;
              nxt_o.hex_accum      = 8'h00;
            end
          end
        end
      end else begin
        // The byte right after a backslash.
        unique case (ch_i)
          qsu_pkg::ChQuote: begin
            res_o.byte_valid = 1'b1;
            res_o.out_byte   = qsu_pkg::ChQuote;
          end
          qsu_pkg::ChBackslash: begin
            res_o.byte_valid = 1'b1;
            res_o.out_byte   = qsu_pkg::ChBackslash;
          end
          qsu_pkg::ChLowerT: begin
            res_o.byte_valid = 1'b1;
            res_o.out_byte   = qsu_pkg::CtrlTab;
          end
          qsu_pkg::ChLowerN: begin
            res_o.byte_valid = 1'b1;
            res_o.out_byte   = qsu_pkg::CtrlLf;
          end
          qsu_pkg::ChLowerR: begin
            res_o.byte_valid = 1'b1;
            res_o.out_byte   = qsu_pkg::CtrlCr;
          end
          qsu_pkg::ChLowerF: begin
            res_o.byte_valid = 1'b1;
            res_o.out_byte   = qsu_pkg::CtrlFf;
          end
          qsu_pkg::ChLowerX: begin
            nxt_o.hex_left  = qsu_pkg::HexDigits;
            nxt_o.hex_accum = 8'h00;
          end
          default: begin
            res_o.status = qsu_pkg::StError;
          end
        endcase
        if (res_o.byte_valid) begin
          nxt_o.escape_pending = 1'b0;
        end
      end
    end else if (ch_i == qsu_pkg::ChBackslash) begin
      nxt_o.escape_pending = 1'b1;
    end else if (ch_i == qsu_pkg::ChQuote) begin
      res_o.status = qsu_pkg::StClose;
    end else begin
      res_o.byte_valid = 1'b1;
      res_o.out_byte   = ch_i;
    end

    // A closing or error result returns everything to the start state.
    if (res_o.status != qsu_pkg::StCont) begin
      res_o.byte_valid = 1'b0;
      res_o.out_byte   = 8'h00;
      nxt_o            = '0;
    end
  end

endmodule

// ===== design/quoted_string_unescaper_core.sv =====
// Decodes the body of a double-quoted string with C-style escapes, one byte
// per transfer, starting with the byte after the opening quote. Every input
// byte gives exactly one result: a decoded byte (byte_valid_o), nothing while
// an escape is still being collected, a close status on the closing quote,
// or an error status for a bad escape, bad or zero hex value, or a zero byte
// before the close. After a close or error the decoder is ready for the next
// string. The block takes one byte per cycle while the output side does not
// stall. A byte is registered on input and decoded against the escape state
// in one step. Its result is then registered on output and offered there
// until it transfers.
module quoted_string_unescaper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       byte_valid_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o
);

  logic                 in_valid_q;
  logic [7:0]           ch_q;
  logic                 out_valid_q;
  qsu_pkg::dec_result_t res_q;
  qsu_pkg::dec_result_t res_d;
  qsu_pkg::dec_state_t  state_q;
  qsu_pkg::dec_state_t  state_d;
  logic                 out_free;
  logic                 advance;
  logic                 in_take;

  // The input register moves on when the result register is free or drains.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  qsu_decode u_decode (
    .ch_i  (ch_q),
    .cur_i (state_q),
    .nxt_o (state_d),
    .res_o (res_d)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q <= ch_i;
    end
  end

  // Escape state and result register, updated as a byte is decoded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_valid_o = res_q.byte_valid;
  assign out_byte_o   = res_q.out_byte;
  assign status_o     = res_q.status;

endmodule

// ===== tb/sv/tb_quoted_string_unescaper_core.sv =====
`timescale 1ns / 1ps

module tb_quoted_string_unescaper_core;

  localparam int RandomBytes = 1000;
  localparam int QuietLimit  = 1000;
  localparam int ReportLimit = 10;
  localparam int DrainCycles = 10;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] ch_i        = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       byte_valid_o;
  logic [7:0] out_byte_o;
  logic [1:0] status_o;

  quoted_string_unescaper_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .ch_i         (ch_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .byte_valid_o (byte_valid_o),
    .out_byte_o   (out_byte_o),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Bytes waiting to be sent and decoded results still owed by the block.
  logic [7:0]           pending_bytes[$];
  qsu_pkg::dec_result_t expected_results[$];
  int                   queued_count = 0;
  int                   fail_count   = 0;
  int                   result_count = 0;
  int                   quiet_cycles = 0;

  // Escape state of the decoder as predicted by the testbench.
  logic       esc_open  = 1'b0;
  logic [1:0] hex_due   = 2'd0;
  logic [7:0] hex_value = 8'h00;

  // Transfer flags seen at the last rising edge, used by the drivers.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  // Sender and receiver pacing.
  int send_wait   = 0;
  int stall_wait  = 0;
  bit send_burst  = 1'b0;
  bit drain_burst = 1'b0;

  logic [7:0] esc_letters[6] = '{qsu_pkg::ChQuote, qsu_pkg::ChBackslash,
                                 qsu_pkg::ChLowerT, qsu_pkg::ChLowerN,
                                 qsu_pkg::ChLowerR, qsu_pkg::ChLowerF};

  // Decodes one byte against the predicted escape state and advances it.
  function automatic qsu_pkg::dec_result_t decode_byte(input logic [7:0] c);
    qsu_pkg::dec_result_t r;
    logic [4:0]           nib;
    r.byte_valid = 1'b0;
    r.out_byte   = 8'h00;
    r.status     = qsu_pkg::StCont;
    // Hex digit value; the top bit marks a byte that is not a digit.
    nib = 5'h10;
    if (c >= "0" && c <= "9") begin
      nib = {1'b0, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      nib = {1'b0, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      nib = {1'b0, 4'(c - "A" + 8'd10)};
    end

    if (c == qsu_pkg::ChEnd) begin
      r.status = qsu_pkg::StError;
    end else if (esc_open) begin
      if (hex_due != 2'd0) begin
        if (nib[4]) begin
          r.status = qsu_pkg::StError;
        end else begin
          hex_due = hex_due - 2'd1;
          if (hex_due == 2'd1) begin
            hex_value = hex_value | {nib[3:0], 4'h0};
          end else begin
            hex_value = hex_value | {4'h0, nib[3:0]};
          end
          if (hex_due == 2'd0) begin
            if (hex_value == 8'h00) begin
              r.status = qsu_pkg::StError;
            end else begin
              r.byte_valid = 1'b1;
              r.out_byte   = hex_value;
              esc_open     = 1'b0;
              hex_value    = 8'h00;
            end
          end
        end
      end else begin
        case (c)
          qsu_pkg::ChQuote: begin
            r.byte_valid = 1'b1;
            r.out_byte   = qsu_pkg::ChQuote;
          end
          qsu_pkg::ChBackslash: begin
            r.byte_valid = 1'b1;
            r.out_byte   = qsu_pkg::ChBackslash;
          end
          qsu_pkg::ChLowerT: begin
            r.byte_valid = 1'b1;
            r.out_byte   = qsu_pkg::CtrlTab;
          end
          qsu_pkg::ChLowerN: begin
            r.byte_valid = 1'b1;
            r.out_byte   = qsu_pkg::CtrlLf;
          end
          qsu_pkg::ChLowerR: begin
            r.byte_valid = 1'b1;
            r.out_byte   = qsu_pkg::CtrlCr;
          end
          qsu_pkg::ChLowerF: begin
            r.byte_valid = 1'b1;
            r.out_byte   = qsu_pkg::CtrlFf;
          end
          qsu_pkg::ChLowerX: begin
            hex_due   = qsu_pkg::HexDigits;
            hex_value = 8'h00;
          end
          default: begin
            r.status = qsu_pkg::StError;
          end
        endcase
        if (r.byte_valid) esc_open = 1'b0;
      end
    end else if (c == qsu_pkg::ChBackslash) begin
      esc_open = 1'b1;
    end else if (c == qsu_pkg::ChQuote) begin
      r.status = qsu_pkg::StClose;
    end else begin
      r.byte_valid = 1'b1;
      r.out_byte   = c;
    end

    // A close or an error leaves the decoder ready for a new string.
    if (r.status != qsu_pkg::StCont) begin
      r.byte_valid = 1'b0;
      r.out_byte   = 8'h00;
      esc_open     = 1'b0;
      hex_due      = 2'd0;
      hex_value    = 8'h00;
    end
    return r;
  endfunction

  // Rising edge: check output transfers, predict input transfers, watch for a hang.
  always @(posedge clk_i) begin
    qsu_pkg::dec_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("unexpected result: byte_valid=%0d out_byte=%02h status=%0d",
                     byte_valid_o, out_byte_o, status_o);
          end
        end else begin
          want = expected_results.pop_front();
          if (byte_valid_o !== want.byte_valid || out_byte_o !== want.out_byte ||
              status_o !== want.status) begin
            fail_count++;
            if (fail_count <= ReportLimit) begin
              $display({"result %0d: expected byte_valid=%0d out_byte=%02h status=%0d,",
                        " got %0d %02h %0d"},
                       result_count, want.byte_valid, want.out_byte, want.status,
                       byte_valid_o, out_byte_o, status_o);
            end
          end
        end
        result_count++;
      end

      if (in_valid_i && !in_stall_o) begin
        want = decode_byte(ch_i);
        expected_results = {expected_results, want};
      end

      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("*** FAILED ***");
        $finish;
      end

      in_taken  <= in_valid_i && !in_stall_o;
      out_taken <= out_valid_o && !out_stall_i;
    end
  end

  // Falling edge: offer the next byte after a random wait per item.
  always @(negedge clk_i) begin
    logic next_valid;
    if (rst_ni) begin
      next_valid = in_valid_i;
      if (in_taken) begin
        void'(pending_bytes.pop_front());
        next_valid = 1'b0;
        if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
        send_wait = send_burst ? 0 : $urandom_range(0, 9);
      end
      if (!next_valid) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (pending_bytes.size() != 0) begin
          next_valid = 1'b1;
          ch_i <= pending_bytes[0];
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Falling edge: hold off each result for a random number of cycles.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 49) == 0) drain_burst = !drain_burst;
        stall_wait = drain_burst ? 0 : $urandom_range(0, 9);
      end
      if (stall_wait != 0) begin
        out_stall_i <= 1'b1;
        stall_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes = {pending_bytes, b};
    queued_count++;
  endtask

  task automatic push_esc(input logic [7:0] letter);
    push_byte(qsu_pkg::ChBackslash);
    push_byte(letter);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return "0" + 8'(nib);
    return (upper ? "A" : "a") + 8'(nib) - 8'd10;
  endfunction

  // A hex escape with the digits in random case.
  task automatic push_hex(input logic [7:0] value);
    push_esc(qsu_pkg::ChLowerX);
    push_byte(hex_char(value[7:4], 1'($urandom_range(0, 1))));
    push_byte(hex_char(value[3:0], 1'($urandom_range(0, 1))));
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == qsu_pkg::ChQuote || b == qsu_pkg::ChBackslash);
    return b;
  endfunction

  // Mostly well-formed string bodies; the rest end in a broken tail or noise.
  task automatic push_string();
    int pieces;
    pieces = $urandom_range(0, 6);
    repeat (pieces) begin
      case ($urandom_range(0, 3))
        0, 1: push_byte(plain_byte());
        2: push_esc(esc_letters[$urandom_range(0, 5)]);
        default: push_hex(8'($urandom_range(1, 255)));
      endcase
    end
    if ($urandom_range(0, 9) < 8) begin
      push_byte(qsu_pkg::ChQuote);
    end else begin
      case ($urandom_range(0, 5))
        0: push_byte(qsu_pkg::ChEnd);
        1: push_esc(8'($urandom_range(0, 255)));
        2: begin
          push_esc(qsu_pkg::ChLowerX);
          push_byte(8'($urandom_range(0, 255)));
        end
        3: begin
          push_esc(qsu_pkg::ChLowerX);
          push_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
          push_byte(8'($urandom_range(0, 255)));
        end
        4: begin
          push_esc(qsu_pkg::ChLowerX);
          push_byte("0");
          push_byte("0");
        end
        default: begin
          repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // Waits until every byte is sent and every result has come back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  initial begin
    int  random_start;
    bit  paused;
    paused = 1'b0;

    // Directed bytes: extreme values, every escape, and each error case.
    push_byte(8'hff);
    foreach (esc_letters[i]) push_esc(esc_letters[i]);
    push_esc(qsu_pkg::ChLowerX);
    push_byte("a");
    push_byte("F");
    push_byte(qsu_pkg::ChQuote);
    // Unknown escape letter.
    push_esc("q");
    // Quote while hex digits are expected.
    push_esc(qsu_pkg::ChLowerX);
    push_byte(qsu_pkg::ChQuote);
    // Byte that is not a hex digit.
    push_esc(qsu_pkg::ChLowerX);
    push_byte("g");
    // Hex escape with a zero value.
    push_hex(8'h00);
    // End of input before the closing quote.
    push_byte(qsu_pkg::ChEnd);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // The sender holds off here until all results are back.
    wait_drained();

    random_start = queued_count;
    while (queued_count - random_start < RandomBytes) begin
      if (!paused && queued_count - random_start >= RandomBytes / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      push_string();
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
